// ===== sv/kdpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad debounce package
// Key matrix geometry, register indexes, reset values and the legend lookup.
// ----------------------------------------------------------------------------
package kdpe_pkg;

    localparam int KEY_ROWS = 4;
    localparam int KEY_COLS = 4;
    localparam int MAP_W    = 16;
    localparam int KEY_W    = 8;
    localparam int CNT_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam int NUM_KEYS  = (KEY_ROWS * KEY_COLS < MAP_W) ? KEY_ROWS * KEY_COLS : MAP_W;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_SHORT_MAX = 2'd1,
        CFG_HOLD      = 2'd2
    } t_cfg_idx;

    localparam t_cnt DEBOUNCE_RESET  = 16'd15;
    localparam t_cnt SHORT_MAX_RESET = 16'd1000;
    localparam t_cnt HOLD_RESET      = 16'd1500;
    localparam t_cnt CNT_MAX         = '1;

    localparam t_key LEGEND4 [0:3][0:3] = '{
        '{8'h31, 8'h32, 8'h33, 8'h41},
        '{8'h34, 8'h35, 8'h36, 8'h42},
        '{8'h37, 8'h38, 8'h39, 8'h43},
        '{8'h2A, 8'h30, 8'h23, 8'h44}
    };

    function automatic t_key legend_of(input int row, input int col);
        t_key k;
        if (row < 4 && col < 4) begin
            k = LEGEND4[row][col];
        end else begin
            k = t_key'(8'h80 | ((row & 7) << 3) | (col & 7));
        end
        return k;
    endfunction

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == CNT_MAX) ? v : v + t_cnt'(1);
    endfunction

endpackage

// ===== sv/keypad_debounce_press_events.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad debounce with press, short-press, release and hold events
// Picks the first closed key of a 4x4 map, debounces it and flags events.
// ----------------------------------------------------------------------------
// Each input beat on i_in_valid/o_in_stall is one tick of a slow timebase
// carrying the map of closed key contacts. Every beat produces exactly one
// result beat on o_out_valid/i_out_stall with the event flags, the key of the
// event and the current debounced key.
// An accepted beat's result is registered in the output register, or in the
// skid register while the receiver stalls. Throughput is one beat per cycle
// while o_in_stall is low, with a single pass of key encode, counter compare
// and event logic between the state registers and the output register.
// A skid register behind the output register holds one more result while the
// receiver stalls; o_in_stall rises only when that skid register is full.
// Configuration writes on i_cfg_valid/o_cfg_ready are always taken and are
// expected only while the block is idle.
// Reset clears the debounce and press state and the output and skid valid
// flags of the output channel, and loads the default debounce, short and hold limits.
// ----------------------------------------------------------------------------
module keypad_debounce_press_events (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [kdpe_pkg::MAP_W-1:0] i_key_map,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [kdpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kdpe_pkg::CNT_W-1:0] i_cfg_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [kdpe_pkg::KEY_W-1:0] o_event_key,
    output logic                      o_press_event,
    output logic                      o_short_event,
    output logic                      o_release_event,
    output logic                      o_hold_event,
    output logic [kdpe_pkg::KEY_W-1:0] o_stable_key
);
    import kdpe_pkg::*;

    typedef struct packed {
        t_key event_key;
        logic press;
        logic short_ev;
        logic release_ev;
        logic hold;
        t_key stable_key;
    } t_result;

    t_cnt r_debounce, r_short_max, r_hold;

    t_key r_cand, n_cand;
    logic r_settling, n_settling;
    t_cnt r_settle_cnt, n_settle_cnt;
    t_key r_acc, n_acc;
    t_key r_prev, n_prev;
    logic r_pressed, n_pressed;
    t_cnt r_press_cnt, n_press_cnt;

    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid;

    t_key key;
    logic accept, out_take;

    assign accept      = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        key = '0;
        for (int b = NUM_KEYS - 1; b >= 0; b--) begin
            if (i_key_map[b]) begin
                key = legend_of(b / KEY_COLS, b % KEY_COLS);
            end
        end
    end

    always_comb begin
        n_cand       = r_cand;
        n_settling   = r_settling;
        n_settle_cnt = sat_inc(r_settle_cnt);
        n_acc        = r_acc;
        n_prev       = r_prev;
        n_pressed    = r_pressed;
        n_press_cnt  = sat_inc(r_press_cnt);
        n_res        = '0;

        if (key != r_cand) begin
            n_settling   = 1'b1;
            n_settle_cnt = '0;
            n_cand       = key;
        end
        if (n_settling && n_settle_cnt >= r_debounce) begin
            n_acc      = n_cand;
            n_settling = 1'b0;
        end
        if (n_acc != r_prev) begin
            if (n_acc != '0) begin
                n_pressed       = 1'b1;
                n_press_cnt     = '0;
                n_res.press     = 1'b1;
                n_res.event_key = n_acc;
            end else begin
                n_pressed        = 1'b0;
                n_res.short_ev   = (n_press_cnt <= r_short_max);
                n_res.release_ev = 1'b1;
                n_res.event_key  = r_prev;
            end
            n_prev = n_acc;
        end
        if (n_pressed && n_press_cnt >= r_hold) begin
            n_res.hold      = 1'b1;
            n_pressed       = 1'b0;
            n_res.event_key = n_acc;
        end
        n_res.stable_key = n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= DEBOUNCE_RESET;
            r_short_max <= SHORT_MAX_RESET;
            r_hold      <= HOLD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:  r_debounce  <= i_cfg_data;
                CFG_SHORT_MAX: r_short_max <= i_cfg_data;
                CFG_HOLD:      r_hold      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand       <= '0;
            r_settling   <= 1'b0;
            r_settle_cnt <= '0;
            r_acc        <= '0;
            r_prev       <= '0;
            r_pressed    <= 1'b0;
            r_press_cnt  <= '0;
        end else if (accept) begin
            r_cand       <= n_cand;
            r_settling   <= n_settling;
            r_settle_cnt <= n_settle_cnt;
            r_acc        <= n_acc;
            r_prev       <= n_prev;
            r_pressed    <= n_pressed;
            r_press_cnt  <= n_press_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (accept && r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end
            if (r_skid_valid) begin
                r_out_valid <= 1'b1;
            end else if (accept) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (!r_out_valid || out_take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_key     = r_out.event_key;
    assign o_press_event   = r_out.press;
    assign o_short_event   = r_out.short_ev;
    assign o_release_event = r_out.release_ev;
    assign o_hold_event    = r_out.hold;
    assign o_stable_key    = r_out.stable_key;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the keypad debounce and press event block
// Sends key contact maps as input beats and keeps its own model of the
// debounce filter and the press, short, release and hold events. Every result
// beat is compared field by field against the oldest expected result. Both
// channels idle at random, the receiver holds off once for a long stretch,
// and the limit registers are changed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
    import kdpe_pkg::*;

    typedef logic [MAP_W-1:0] t_map;

    typedef struct packed {
        t_key event_key;
        logic press_ev;
        logic short_ev;
        logic release_ev;
        logic hold_ev;
        t_key stable_key;
    } t_key_result;

    localparam t_cnt RESET_DEBOUNCE  = 16'd15;
    localparam t_cnt RESET_SHORT_MAX = 16'd1000;
    localparam t_cnt RESET_HOLD      = 16'd1500;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam t_key KEYPAD_LEGENDS [16] = '{
        8'h31, 8'h32, 8'h33, 8'h41,
        8'h34, 8'h35, 8'h36, 8'h42,
        8'h37, 8'h38, 8'h39, 8'h43,
        8'h2A, 8'h30, 8'h23, 8'h44
    };

    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLDOFF_LEN     = 60;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_TICKS     = 90;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_map                 i_key_map;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    t_cnt                 i_cfg_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_key                 o_event_key;
    logic                 o_press_event;
    logic                 o_short_event;
    logic                 o_release_event;
    logic                 o_hold_event;
    t_key                 o_stable_key;

    keypad_debounce_press_events uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_key_map       (i_key_map),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_key     (o_event_key),
        .o_press_event   (o_press_event),
        .o_short_event   (o_short_event),
        .o_release_event (o_release_event),
        .o_hold_event    (o_hold_event),
        .o_stable_key    (o_stable_key)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Debounce model state and its copy of the limit registers.
    t_cnt debounce_lim = RESET_DEBOUNCE;
    t_cnt short_lim    = RESET_SHORT_MAX;
    t_cnt hold_lim     = RESET_HOLD;
    t_key cand_key     = '0;
    logic settling     = 1'b0;
    t_cnt settle_ticks = '0;
    t_key debounced    = '0;
    t_key reported     = '0;
    logic hold_armed   = 1'b0;
    t_cnt held_ticks   = '0;

    t_key_result expected_q[$];
    t_key_result want;
    int          errors = 0;
    int          ticks_sent = 0;
    int          quiet_cycles = 0;
    int          holdoff_cycles = 0;
    bit          idling = 1'b0;

    function automatic t_key first_closed_key(input t_map map);
        t_key key;
        int   idx;
        key = '0;
        for (int r = KEY_ROWS - 1; r >= 0; r--) begin
            for (int c = KEY_COLS - 1; c >= 0; c--) begin
                idx = r * KEY_COLS + c;
                if (idx < MAP_W && map[idx]) begin
                    if (r < 4 && c < 4) begin
                        key = KEYPAD_LEGENDS[r * 4 + c];
                    end else begin
                        key = t_key'(8'h80 | ((r & 7) << 3) | (c & 7));
                    end
                end
            end
        end
        return key;
    endfunction

    task automatic predict_tick(input t_map map);
        t_key        key;
        t_key_result res;
        key = first_closed_key(map);
        res = '0;
        settle_ticks = (settle_ticks == '1) ? settle_ticks : settle_ticks + 1'b1;
        held_ticks   = (held_ticks == '1) ? held_ticks : held_ticks + 1'b1;
        if (key != cand_key) begin
            settling     = 1'b1;
            settle_ticks = '0;
            cand_key     = key;
        end
        if (settling && settle_ticks >= debounce_lim) begin
            debounced = cand_key;
            settling  = 1'b0;
        end
        if (debounced != reported) begin
            if (debounced != '0) begin
                hold_armed    = 1'b1;
                held_ticks    = '0;
                res.press_ev  = 1'b1;
                res.event_key = debounced;
            end else begin
                hold_armed     = 1'b0;
                res.short_ev   = (held_ticks <= short_lim);
                res.release_ev = 1'b1;
                res.event_key  = reported;
            end
            reported = debounced;
        end
        if (hold_armed && held_ticks >= hold_lim) begin
            res.hold_ev   = 1'b1;
            hold_armed    = 1'b0;
            res.event_key = debounced;
        end
        res.stable_key = debounced;
        expected_q.push_back(res);
    endtask

    function automatic t_map map_with_key(input int pos);
        t_map m;
        m = t_map'($urandom);
        m = m & ~((t_map'(1) << pos) - t_map'(1));
        return m | (t_map'(1) << pos);
    endfunction

    task automatic send_tick(input t_map map);
        if (idling && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_key_map  <= map;
        do @(posedge i_clk); while (o_in_stall);
        predict_tick(map);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_cnt value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEBOUNCE:  debounce_lim = value;
            CFG_SHORT_MAX: short_lim = value;
            CFG_HOLD:      hold_lim = value;
            default:       ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_limits(input t_cnt deb, input t_cnt shrt, input t_cnt hld);
        wait_idle();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_SHORT_MAX, shrt);
        write_reg(CFG_HOLD, hld);
    endtask

    task automatic keystroke(input int span);
        int pos;
        repeat ($urandom_range(0, 3)) send_tick(t_map'($urandom));
        pos = $urandom_range(0, NUM_KEYS - 1);
        repeat ($urandom_range(1, span)) send_tick(map_with_key(pos));
        if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(0, 3)) send_tick(t_map'($urandom));
            repeat ($urandom_range(1, span)) send_tick('0);
        end
    endtask

    task automatic test_reset_limits();
        idling = 1'b1;
        repeat (3) send_tick(t_map'($urandom));
        repeat (20) send_tick(map_with_key(8));
        repeat (20) send_tick('0);
        repeat (60) send_tick(map_with_key(15));
        repeat (20) send_tick('0);
        wait_idle();
    endtask

    task automatic test_zero_limits();
        idling = 1'b0;
        set_limits(16'd0, 16'd1, 16'd0);
        send_tick(t_map'(16'h8000));
        send_tick('0);
        send_tick(t_map'(16'hFFFF));
        send_tick(t_map'(16'h8000));
        send_tick('0);
        wait_idle();
    endtask

    task automatic test_every_key();
        set_limits(16'd0, 16'd0, 16'd3);
        for (int k = 0; k < NUM_KEYS; k++) send_tick(t_map'(1) << k);
        send_tick('0);
        wait_idle();
    endtask

    task automatic test_random_keystrokes();
        int span;
        int start;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_limits(16'd0, 16'd0, 16'hFFFF);
                1: set_limits(t_cnt'($urandom_range(1, 4)), 16'hFFFF, 16'd0);
                default: set_limits(t_cnt'($urandom_range(0, 6)),
                                    t_cnt'($urandom_range(0, 25)),
                                    t_cnt'($urandom_range(0, 40)));
            endcase
            span = debounce_lim + 8 + (short_lim < 100 ? short_lim : 0)
                   + (hold_lim < 100 ? hold_lim : 0);
            start = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS) begin
                idling = ($urandom_range(0, 4) != 0);
                keystroke(span);
            end
        end
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        idling = 1'b0;
        set_limits(16'd2, 16'd10, 16'd20);
        holdoff_cycles = HOLDOFF_LEN;
        for (int k = 0; k < 40; k++) send_tick(k < 25 ? map_with_key(5) : t_map'(0));
        wait_idle();
    endtask

    task automatic test_drain_pause();
        idling = 1'b1;
        set_limits(16'd1, 16'd6, 16'd9);
        repeat (8) send_tick(map_with_key(10));
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        repeat (8) send_tick('0);
        wait_idle();
    endtask

    task automatic test_spare_register();
        idling = 1'b0;
        set_limits(16'd3, 16'd8, 16'd12);
        write_reg(CFG_SPARE, 16'h0007);
        repeat (20) send_tick(map_with_key(2));
        repeat (20) send_tick('0);
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $error("result beat with no expected result waiting");
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (o_event_key !== want.event_key) begin
                    $error("event_key: expected %h, got %h", want.event_key, o_event_key);
                    errors++;
                end
                if (o_press_event !== want.press_ev) begin
                    $error("press_event: expected %b, got %b", want.press_ev, o_press_event);
                    errors++;
                end
                if (o_short_event !== want.short_ev) begin
                    $error("short_event: expected %b, got %b", want.short_ev, o_short_event);
                    errors++;
                end
                if (o_release_event !== want.release_ev) begin
                    $error("release_event: expected %b, got %b",
                           want.release_ev, o_release_event);
                    errors++;
                end
                if (o_hold_event !== want.hold_ev) begin
                    $error("hold_event: expected %b, got %b", want.hold_ev, o_hold_event);
                    errors++;
                end
                if (o_stable_key !== want.stable_key) begin
                    $error("stable_key: expected %h, got %h", want.stable_key, o_stable_key);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_cycles != 0) begin
                i_out_stall <= 1'b1;
                repeat (holdoff_cycles) @(negedge i_clk);
                holdoff_cycles = 0;
                i_out_stall <= 1'b0;
            end else if (idling && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_key_map   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_limits();
        test_zero_limits();
        test_every_key();
        test_random_keystrokes();
        test_output_backpressure();
        test_drain_pause();
        test_spare_register();

        repeat (10) @(negedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
